>>> rtl/core/ffpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit page run allocator.
// No dependencies.
package ffpa_pkg;

  localparam int MODE_W     = 1;
  localparam int COUNT_W    = 11;
  localparam int SLOT_W     = 10;
  localparam int WORD_BITS  = 16;
  localparam int WORD_IDX_W = 4;

  typedef logic [WORD_BITS-1:0] word_t;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result codes
  localparam logic RES_DONE     = 1'b0;
  localparam logic RES_NO_SPACE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_FILL,
    S_FINISH
  } ffpa_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic fill;
    logic out_load;
  } ffpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic skip;
    logic hit;
    logic miss;
    logic fill_done;
  } ffpa_sts_t;

endpackage

>>> rtl/core/ffpa_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready).
// Depends on ffpa_pkg.
interface ffpa_in_if import ffpa_pkg::*;;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COUNT_W-1:0] page_count;
  logic [SLOT_W-1:0]  slot_index;

  modport source (output valid, output mode, output page_count, output slot_index,
                  input ready);
  modport sink   (input valid, input mode, input page_count, input slot_index,
                  output ready);
endinterface

interface ffpa_out_if import ffpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [SLOT_W-1:0] start_slot;

  modport source (output valid, output status, output start_slot, input ready);
  modport sink   (input valid, input status, input start_slot, output ready);
endinterface

>>> rtl/core/ffpa_datapath.sv
`timescale 1ns / 1ps
// Slot map memory, word scanner, range fill and result registers.
// Depends on ffpa_pkg; driven by ffpa_ctrl.
module ffpa_datapath import ffpa_pkg::*; #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  ffpa_cmd_t          cmd,
  output ffpa_sts_t          sts,
  input  logic               in_mode,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [SLOT_W-1:0]  in_slot,
  output logic               out_status,
  output logic [SLOT_W-1:0]  out_start
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int RW    = SW + 1;
  localparam int XW    = ((SW > COUNT_W) ? SW : COUNT_W) + 1;
  localparam int WORDS = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TAIL  = SLOT_COUNT - (WORDS - 1) * WORD_BITS;

  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [XW-1:0] LAST_SLOT = XW'(SLOT_COUNT - 1);
  localparam word_t WORD_ALL  = {WORD_BITS{1'b1}};
  localparam word_t TAIL_USED = ~(WORD_ALL >> (WORD_BITS - TAIL));

  word_t             mem [WORDS];
  word_t             rdata;
  logic [AW-1:0]     rd_ptr, ev_ptr;
  logic              rd_more, ev_vld;
  logic              mode_r;
  logic [COUNT_W-1:0] count_r;
  logic [XW-1:0]     lo, hi;
  logic [RW-1:0]     run_cnt;
  logic              skip;
  logic              res_status;
  logic [SLOT_W-1:0] res_start;

  logic [AW-1:0]     lo_w, hi_w, stop_w;
  word_t             used;
  logic [XW-1:0]     run_j [WORD_BITS];
  logic [WORD_BITS-1:0] hit_vec;
  logic [WORD_IDX_W:0]  loc;
  logic              free_all;
  logic [WORD_IDX_W-1:0] hit_pos;
  logic [XW-1:0]     hit_slot, hit_lo;
  logic              scan_eval, hit, miss, issue;
  logic [XW-1:0]     f_lo, f_end, f_hi;
  logic              f_empty;
  word_t             lo_m, hi_m, fill_m;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  word_t             wr_data;

  assign lo_w = lo[AW+WORD_IDX_W-1:WORD_IDX_W];
  assign hi_w = hi[AW+WORD_IDX_W-1:WORD_IDX_W];

  // run length ending at each bit of the word under evaluation
  always_comb begin
    loc      = '0;
    free_all = 1'b1;
    hit_pos  = '0;
    used     = rdata | ((ev_ptr == LAST_WORD) ? TAIL_USED : '0);
    for (int j = 0; j < WORD_BITS; j++) begin
      loc      = (WORD_IDX_W+1)'(0);
      free_all = 1'b1;
      for (int k = 0; k <= j; k++) begin
        if (used[k]) begin
          loc      = (WORD_IDX_W+1)'(j - k);
          free_all = 1'b0;
        end
      end
      run_j[j]   = free_all ? (XW'(run_cnt) + XW'(j + 1)) : XW'(loc);
      hit_vec[j] = (run_j[j] >= XW'(count_r));
    end
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_pos = WORD_IDX_W'(j);
      end
    end
    hit_slot = XW'({ev_ptr, hit_pos});
    hit_lo   = hit_slot + XW'(1) - XW'(count_r);
  end

  assign scan_eval = cmd.scan && ev_vld;
  assign hit       = scan_eval && (|hit_vec);
  assign miss      = scan_eval && !(|hit_vec) && (ev_ptr == LAST_WORD);

  // free range, clipped at the last slot
  always_comb begin
    f_lo    = XW'(in_slot);
    f_end   = f_lo + XW'(in_count) - XW'(1);
    f_hi    = (f_end > LAST_SLOT) ? LAST_SLOT : f_end;
    f_empty = (in_count == '0) || (f_lo > LAST_SLOT);
  end

  // bit mask of the range within the word being written
  always_comb begin
    lo_m   = (ev_ptr == lo_w) ? (WORD_ALL << lo[WORD_IDX_W-1:0]) : WORD_ALL;
    hi_m   = (ev_ptr == hi_w) ? (WORD_ALL >> (~hi[WORD_IDX_W-1:0])) : WORD_ALL;
    fill_m = lo_m & hi_m;
  end

  assign stop_w = cmd.scan ? LAST_WORD : hi_w;
  assign issue  = (cmd.scan || cmd.fill) && rd_more && !hit;

  always_comb begin
    wr_en   = cmd.clear || (cmd.fill && ev_vld);
    wr_addr = cmd.clear ? rd_ptr : ev_ptr;
    if (cmd.clear) begin
      wr_data = '0;
    end else if (mode_r == MODE_FREE) begin
      wr_data = rdata & ~fill_m;
    end else begin
      wr_data = rdata | fill_m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      rd_more <= 1'b0;
      ev_vld  <= 1'b0;
    end else if (cmd.load) begin
      rd_ptr  <= (in_mode == MODE_FREE) ? f_lo[AW+WORD_IDX_W-1:WORD_IDX_W] : '0;
      rd_more <= 1'b1;
      ev_vld  <= 1'b0;
    end else if (cmd.clear) begin
      rd_ptr  <= (rd_ptr == LAST_WORD) ? '0 : rd_ptr + AW'(1);
    end else if (hit) begin
      rd_ptr  <= hit_lo[AW+WORD_IDX_W-1:WORD_IDX_W];
      rd_more <= 1'b1;
      ev_vld  <= 1'b0;
    end else begin
      ev_vld <= issue;
      if (issue) begin
        rd_more <= (rd_ptr != stop_w);
        if (rd_ptr != stop_w) begin
          rd_ptr <= rd_ptr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata  <= mem[rd_ptr];
    ev_ptr <= rd_ptr;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      mode_r     <= in_mode;
      count_r    <= in_count;
      run_cnt    <= '0;
      lo         <= f_lo;
      hi         <= f_hi;
      skip       <= (in_mode == MODE_FREE) ? f_empty : (in_count == '0);
      res_status <= (in_mode == MODE_FREE) ? RES_DONE : RES_NO_SPACE;
      res_start  <= '0;
    end
    if (scan_eval) begin
      run_cnt <= RW'(run_j[WORD_BITS-1]);
    end
    if (hit) begin
      lo         <= hit_lo;
      hi         <= hit_slot;
      res_status <= RES_DONE;
      res_start  <= hit_lo[SLOT_W-1:0];
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_start  <= res_start;
    end
  end

  always_comb begin
    sts.clear_last = (rd_ptr == LAST_WORD);
    sts.is_free    = (mode_r == MODE_FREE);
    sts.skip       = skip;
    sts.hit        = hit;
    sts.miss       = miss;
    sts.fill_done  = cmd.fill && ev_vld && (ev_ptr == hi_w);
  end

endmodule

>>> rtl/core/ffpa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: clearing pass, request intake, scan/fill phases, result hand-off.
// Depends on ffpa_pkg.
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ffpa_sts_t sts,
  output ffpa_cmd_t cmd
);

  ffpa_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_START;
      S_START: begin
        if (sts.skip) begin
          state_next = S_FINISH;
        end else if (sts.is_free) begin
          state_next = S_FILL;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_next = S_FILL;
        end else if (sts.miss) begin
          state_next = S_FINISH;
        end
      end
      S_FILL:   if (sts.fill_done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:   cmd.scan = 1'b1;
      S_FILL:   cmd.fill = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/first_fit_page_run_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit page run allocator.
// Depends on ffpa_pkg, ffpa_if, ffpa_ctrl, ffpa_datapath.
//
//  channel | dir | fields                            | beat
//  in_ch   | in  | mode, page_count, slot_index      | one request
//  out_ch  | out | status, start_slot                | one result per request
//
// Operation: the slot map is kept as 16-slot words in a memory with a
// registered read. An allocate reads words from slot 0 up, one per cycle,
// until the run is found, then read-modify-writes the run's words, one per
// cycle. A free read-modify-writes the words of its range, and a skipped
// request goes straight to the result.
// Reset: a clearing pass writes every word to zero, with in_ch.ready low.
// Stalls: one request is worked on at a time; a finished result sits in the
// output register while the next request is taken, and the next result
// waits until that one is taken.
module first_fit_page_run_allocator import ffpa_pkg::*; #(
  parameter int SLOT_COUNT = 1024
) (
  input logic        clk,
  input logic        rst,
  ffpa_in_if.sink    in_ch,
  ffpa_out_if.source out_ch
);

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  // sequencer
  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot map and scan/fill logic
  ffpa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_ch.mode),
    .in_count   (in_ch.page_count),
    .in_slot    (in_ch.slot_index),
    .out_status (out_ch.status),
    .out_start  (out_ch.start_slot)
  );

endmodule

>>> rtl/core/ffpa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the allocator, bound to the top level.
// Depends on ffpa_pkg and first_fit_page_run_allocator.
module ffpa_port_checker import ffpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              status,
  input logic [SLOT_W-1:0] start_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(start_slot))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == RES_NO_SPACE) |-> (start_slot == '0))
    else $error("failed allocate with nonzero start");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind first_fit_page_run_allocator ffpa_port_checker u_ffpa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .start_slot (out_ch.start_slot)
);

>>> bench/ffpa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the first-fit page run allocator: tracks the slot map,
// predicts each result and compares it beat by beat. Depends on ffpa_pkg.
module ffpa_checker import ffpa_pkg::*; #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [SLOT_W-1:0]  in_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_status,
  input  logic [SLOT_W-1:0]  out_start,
  output int                 pending,
  output int                 errors,
  output int                 allocs,
  output int                 grants,
  output int                 frees
);

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] start_slot;
  } grant_t;

  logic   page_busy [SLOT_COUNT];
  grant_t grant_q [$];

  // Applies one request to the slot map and returns the result it should give.
  function automatic grant_t first_fit_grant(input logic mode, input logic [COUNT_W-1:0] cnt,
                                             input logic [SLOT_W-1:0] base);
    grant_t g;
    int     run;
    int     first;
    logic   found;
    g.status     = RES_DONE;
    g.start_slot = '0;
    if (mode == MODE_ALLOC) begin
      run   = 0;
      first = 0;
      found = 1'b0;
      if (cnt != 0) begin
        for (int i = 0; i < SLOT_COUNT && !found; i++) begin
          if (!page_busy[i]) begin
            run++;
            if (run == int'(cnt)) begin
              first = i + 1 - run;
              for (int k = first; k <= i; k++) page_busy[k] = 1'b1;
              found = 1'b1;
            end
          end else begin
            run = 0;
          end
        end
      end
      if (found) begin
        g.start_slot = first[SLOT_W-1:0];
      end else begin
        g.status = RES_NO_SPACE;
      end
    end else begin
      // slots past the end are dropped, the rest cleared
      for (int i = 0; i < int'(cnt); i++) begin
        if (int'(base) + i < SLOT_COUNT) page_busy[int'(base) + i] = 1'b0;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      foreach (page_busy[i]) page_busy[i] = 1'b0;
      grant_q.delete();
      errors = 0;
      allocs = 0;
      grants = 0;
      frees  = 0;
    end else begin
      if (in_valid && in_ready) begin
        want = first_fit_grant(in_mode, in_count, in_index);
        grant_q.push_back(want);
        if (in_mode == MODE_ALLOC) begin
          allocs++;
          if (want.status == RES_DONE) grants++;
        end else begin
          frees++;
        end
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("result with nothing expected: status %0d start_slot %0d",
                 out_status, out_start);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_start !== want.start_slot) begin
            $error("start_slot: expected %0d, got %0d", want.start_slot, out_start);
            errors++;
          end
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

>>> bench/tb_first_fit_page_run_allocator.sv
`timescale 1ns / 1ps
// Top of the allocator bench: clock, reset, request/result drivers, watchdog.
// Depends on ffpa_pkg, ffpa_if, ffpa_checker and first_fit_page_run_allocator.
module tb_first_fit_page_run_allocator;
  import ffpa_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int PHASE_ITEMS  = 382;   // random beats per idle mix
  localparam int HOLD_CYCLES  = 300;   // long result back-pressure stretch
  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES  = 150;   // tail wait, longer than the longest request

  logic clk = 1'b0;
  logic rst = 1'b1;

  // idle mix, in percent per cycle
  int   src_idle  = 0;
  int   rcv_stall = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  int pending, errors, allocs, grants, frees;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  ffpa_in_if  in_ch ();
  ffpa_out_if out_ch ();

  first_fit_page_run_allocator #(.SLOT_COUNT(SLOTS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ffpa_checker #(.SLOT_COUNT(SLOTS)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_count   (in_ch.page_count),
    .in_index   (in_ch.slot_index),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_start  (out_ch.start_slot),
    .pending    (pending),
    .errors     (errors),
    .allocs     (allocs),
    .grants     (grants),
    .frees      (frees)
  );

  // One request beat. Valid is left high on return; the next call either
  // drops it for an idle gap or replaces the payload, so valid never takes
  // two assignments in one step.
  task automatic send_request(input logic m, input logic [COUNT_W-1:0] c,
                              input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = m;
    in_ch.page_count = c;
    in_ch.slot_index = s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Random traffic. First fit packs allocations at the bottom of the map, so
  // most frees aim at the low slots where live runs sit; a few run off the
  // top end, and now and then the whole map is released so that large
  // allocations keep a chance of fitting.
  task automatic random_request();
    int                 r;
    int                 sz;
    logic [COUNT_W-1:0] c;
    logic [SLOT_W-1:0]  s;
    r  = $urandom_range(99);
    sz = $urandom_range(99);
    s  = SLOT_W'($urandom_range(SLOTS - 1));
    if (r < 52) begin
      if (sz < 70)      c = COUNT_W'($urandom_range(16, 1));
      else if (sz < 90) c = COUNT_W'($urandom_range(128, 17));
      else if (sz < 97) c = COUNT_W'($urandom_range(1024, 129));
      else              c = COUNT_W'($urandom_range(2047));   // zero and oversize too
      send_request(MODE_ALLOC, c, s);
    end else if (r < 91) begin
      s = SLOT_W'($urandom_range(383));
      c = (sz < 5) ? '0 : COUNT_W'($urandom_range(48, 1));
      send_request(MODE_FREE, c, s);
    end else if (r < 97) begin
      s = SLOT_W'($urandom_range(SLOTS - 1, SLOTS - 64));
      c = COUNT_W'($urandom_range(2047));
      send_request(MODE_FREE, c, s);
    end else begin
      send_request(MODE_FREE, COUNT_W'(SLOTS), '0);
    end
  endtask

  // Sender pause: park valid and wait for every outstanding result.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random stalls at rcv_stall percent, plus one long hold-off
  // on request, counted here so the sender keeps pushing meanwhile.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done    = 1'b1;
        out_ch.ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= rcv_stall);
    end
  end

  // Watchdog: the run is stuck if no beat moves on either channel for too long.
  // The post-reset clearing pass and the hold-off fit well inside.
  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_ALLOC;
    in_ch.page_count = '0;
    in_ch.slot_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-map extremes, zero and oversize counts, word-crossing
    // runs, holes reused, frees of free slots, frees off the top end, an
    // exactly full map and the very last slot.
    send_request(MODE_ALLOC, 11'd1024, 10'd1023);  // whole map at once
    send_request(MODE_FREE,  11'd1024, 10'd0);
    send_request(MODE_ALLOC, 11'd0,    10'd0);     // zero pages: refused
    send_request(MODE_ALLOC, 11'd1025, 10'd0);     // more than the map
    send_request(MODE_ALLOC, 11'd2047, 10'd512);
    send_request(MODE_ALLOC, 11'd1,    10'd0);
    send_request(MODE_ALLOC, 11'd3,    10'd0);
    send_request(MODE_ALLOC, 11'd16,   10'd0);     // straddles a map word
    send_request(MODE_FREE,  11'd3,    10'd1);     // punch a hole
    send_request(MODE_ALLOC, 11'd4,    10'd0);     // too big for the hole
    send_request(MODE_ALLOC, 11'd2,    10'd0);     // fits the hole
    send_request(MODE_FREE,  11'd0,    10'd5);     // zero-page free
    send_request(MODE_FREE,  11'd10,   10'd500);   // already free
    send_request(MODE_FREE,  11'd2047, 10'd1023);  // runs far past the end
    send_request(MODE_FREE,  11'd100,  10'd1000);
    send_request(MODE_FREE,  11'd1024, 10'd0);
    send_request(MODE_ALLOC, 11'd512,  10'd0);
    send_request(MODE_ALLOC, 11'd512,  10'd0);     // map now exactly full
    send_request(MODE_ALLOC, 11'd1,    10'd0);     // refused
    send_request(MODE_FREE,  11'd1,    10'd1023);
    send_request(MODE_ALLOC, 11'd1,    10'd0);     // lands on the last slot
    send_request(MODE_FREE,  11'd2047, 10'd0);
    drain();

    // Random phases under each idle mix; the long result hold-off lands in
    // the unthrottled phase so the block fills up and stalls its input.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle = 0;  rcv_stall = 0;  end
        1:       begin src_idle = 55; rcv_stall = 0;  end
        2:       begin src_idle = 0;  rcv_stall = 55; end
        default: begin src_idle = 36; rcv_stall = 36; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 120) hold_req = 1'b1;
        random_request();
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d requests: %0d allocate (%0d granted, %0d refused), %0d free.",
             allocs + frees, allocs, grants, allocs - grants, frees);
    $display("Idle mixes: none, sender 55%%, receiver 55%%, both 36%%; %0s %0d-cycle %0s",
             "one", HOLD_CYCLES, "result hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
